FILE: rtl/core/assert_macros.svh
// Assertion macros for the SHA-1 hasher RTL.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while arst_n is high.
`define SHA1H_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SHA1H_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sha1h_pkg.sv
// Package for the SHA-1 byte stream hasher: state and command types, constants.
// No dependencies; used by the controller, the datapath and the top level.
package sha1h_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN,
		PAD_DONE
	} pad_t;

	typedef enum logic [1:0] {
		BSEL_INPUT,
		BSEL_MARK,
		BSEL_ZERO,
		BSEL_LEN
	} bsel_t;

	typedef struct packed {
		logic        push;
		bsel_t       bsel;
		logic [2:0]  len_idx;
		logic        count;
		logic        load;
		logic        round;
		logic [6:0]  round_idx;
		logic        fold;
		logic [2:0]  word_idx;
		logic        clear;
	} cmd_t;

	localparam logic [31:0] H_INIT [0:4] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] ROUND_K [0:3] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] FILL_LEN   = 6'd56;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] W_DIRECT   = 7'd16;
	localparam logic [6:0] ROUND_B1   = 7'd20;
	localparam logic [6:0] ROUND_B2   = 7'd40;
	localparam logic [6:0] ROUND_B3   = 7'd60;
	localparam logic [2:0] LEN_LAST   = 3'd7;
	localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

FILE: rtl/core/sha1h_ctrl.sv
// Controller of the SHA-1 hasher: handshakes, block fill, padding and round sequencing.
// Depends on sha1h_pkg and assert_macros.svh; drives the datapath through cmd_t.
`include "assert_macros.svh"

module sha1h_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              has_byte,
	input  logic              end_of_message,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        word_index,
	output logic              last_word,
	output sha1h_pkg::cmd_t   cmd
);

	sha1h_pkg::state_t state_q, state_d;
	sha1h_pkg::pad_t   pad_q, pad_d;
	logic [5:0]        fill_q, fill_d;
	logic [6:0]        round_q, round_d;
	logic [2:0]        len_q, len_d;
	logic [2:0]        emit_q, emit_d;
	logic              fin_q, fin_d;
	logic              in_take;
	logic              pad_push;
	logic              push;

	assign in_take  = (state_q == sha1h_pkg::ST_IDLE) && in_valid;
	assign pad_push = (state_q == sha1h_pkg::ST_PAD) &&
		!((pad_q == sha1h_pkg::PAD_ZERO) && (fill_q == sha1h_pkg::FILL_LEN));
	assign push     = (in_take && has_byte) || pad_push;

	always_comb begin
		state_d = state_q;
		pad_d   = pad_q;
		fill_d  = fill_q;
		round_d = round_q;
		len_d   = len_q;
		emit_d  = emit_q;
		fin_d   = fin_q;
		case (state_q)
			sha1h_pkg::ST_IDLE: begin
				if (in_valid) begin
					fin_d = end_of_message;
					pad_d = sha1h_pkg::PAD_MARK;
					len_d = '0;
					if (end_of_message) begin
						state_d = sha1h_pkg::ST_PAD;
					end
				end
			end
			sha1h_pkg::ST_ROUND: begin
				round_d = 7'(round_q + 7'd1);
				if (round_q == sha1h_pkg::ROUND_LAST) begin
					state_d = sha1h_pkg::ST_FOLD;
				end
			end
			sha1h_pkg::ST_FOLD: begin
				if (!fin_q) begin
					state_d = sha1h_pkg::ST_IDLE;
				end else if (pad_q == sha1h_pkg::PAD_DONE) begin
					state_d = sha1h_pkg::ST_EMIT;
				end else begin
					state_d = sha1h_pkg::ST_PAD;
				end
			end
			sha1h_pkg::ST_PAD: begin
				case (pad_q)
					sha1h_pkg::PAD_MARK: begin
						pad_d = sha1h_pkg::PAD_ZERO;
					end
					sha1h_pkg::PAD_ZERO: begin
						if (fill_q == sha1h_pkg::FILL_LEN) begin
							pad_d = sha1h_pkg::PAD_LEN;
						end
					end
					sha1h_pkg::PAD_LEN: begin
						len_d = 3'(len_q + 3'd1);
						if (len_q == sha1h_pkg::LEN_LAST) begin
							pad_d = sha1h_pkg::PAD_DONE;
						end
					end
					default: begin
						pad_d = pad_q;
					end
				endcase
			end
			sha1h_pkg::ST_EMIT: begin
				if (!out_stall) begin
					emit_d = 3'(emit_q + 3'd1);
					if (emit_q == sha1h_pkg::WORD_LAST) begin
						emit_d  = '0;
						fin_d   = 1'b0;
						state_d = sha1h_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sha1h_pkg::ST_IDLE;
			end
		endcase
		if (push) begin
			fill_d = 6'(fill_q + 6'd1);
			if (fill_q == sha1h_pkg::FILL_LAST) begin
				round_d = '0;
				state_d = sha1h_pkg::ST_ROUND;
			end
		end
	end

	always_comb begin
		in_stall      = (state_q != sha1h_pkg::ST_IDLE);
		out_valid     = (state_q == sha1h_pkg::ST_EMIT);
		word_index    = emit_q;
		last_word     = (emit_q == sha1h_pkg::WORD_LAST);
		cmd.push      = push;
		cmd.bsel      = sha1h_pkg::BSEL_INPUT;
		if (state_q == sha1h_pkg::ST_PAD) begin
			case (pad_q)
				sha1h_pkg::PAD_MARK: cmd.bsel = sha1h_pkg::BSEL_MARK;
				sha1h_pkg::PAD_ZERO: cmd.bsel = sha1h_pkg::BSEL_ZERO;
				default:             cmd.bsel = sha1h_pkg::BSEL_LEN;
			endcase
		end
		cmd.len_idx   = len_q;
		cmd.count     = in_take && has_byte;
		cmd.load      = push && (fill_q == sha1h_pkg::FILL_LAST);
		cmd.round     = (state_q == sha1h_pkg::ST_ROUND);
		cmd.round_idx = round_q;
		cmd.fold      = (state_q == sha1h_pkg::ST_FOLD);
		cmd.word_idx  = emit_q;
		cmd.clear     = (state_q == sha1h_pkg::ST_EMIT) && !out_stall &&
			(emit_q == sha1h_pkg::WORD_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1h_pkg::ST_IDLE;
			pad_q   <= sha1h_pkg::PAD_MARK;
			fill_q  <= '0;
			round_q <= '0;
			len_q   <= '0;
			emit_q  <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
			fill_q  <= fill_d;
			round_q <= round_d;
			len_q   <= len_d;
			emit_q  <= emit_d;
			fin_q   <= fin_d;
		end
	end

	`SHA1H_ASSERT(a_emit_blocks_input, out_valid |-> in_stall, "Input taken while digest words are pending.")
	`SHA1H_ASSERT(a_round_range, (state_q == sha1h_pkg::ST_ROUND) |-> (round_q <= sha1h_pkg::ROUND_LAST), "Round counter ran past the last round.")
	`SHA1H_ASSERT(a_load_wraps_fill, cmd.load |=> (fill_q == '0) && (state_q == sha1h_pkg::ST_ROUND), "A full block did not start compression with an empty fill.")
	`SHA1H_ASSERT(a_digest_done, cmd.clear |=> (state_q == sha1h_pkg::ST_IDLE) && (fill_q == '0) && !fin_q, "Controller did not return to its initial state after the digest.")
	`SHA1H_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (state_q == sha1h_pkg::ST_IDLE), "Controller left idle during reset.")

endmodule

FILE: rtl/core/sha1h_dp.sv
// Datapath of the SHA-1 hasher: block and schedule window, round registers, chaining words.
// Depends on sha1h_pkg; controlled by sha1h_ctrl through cmd_t.
module sha1h_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1h_pkg::cmd_t   cmd,
	input  logic [7:0]        data_byte,
	output logic [31:0]       digest_word
);

	logic [511:0] blk_q;
	logic [31:0]  h_q [0:4];
	logic [63:0]  bit_cnt_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [7:0]   push_byte;
	logic [5:0]   len_shift;
	logic [31:0]  sched_x;
	logic [31:0]  wt;
	logic [31:0]  f;
	logic [31:0]  k;
	logic [31:0]  t;

	assign len_shift = {3'(~cmd.len_idx), 3'b000};

	always_comb begin
		case (cmd.bsel)
			sha1h_pkg::BSEL_INPUT: push_byte = data_byte;
			sha1h_pkg::BSEL_MARK:  push_byte = sha1h_pkg::PAD_BYTE;
			sha1h_pkg::BSEL_ZERO:  push_byte = '0;
			default:               push_byte = 8'(bit_cnt_q >> len_shift);
		endcase
	end

	// The window holds sixteen schedule words, the oldest in the top bits.
	assign sched_x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
	assign wt = (cmd.round_idx < sha1h_pkg::W_DIRECT) ? blk_q[511:480] :
		{sched_x[30:0], sched_x[31]};

	always_comb begin
		if (cmd.round_idx < sha1h_pkg::ROUND_B1) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1h_pkg::ROUND_K[0];
		end else if (cmd.round_idx < sha1h_pkg::ROUND_B2) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1h_pkg::ROUND_K[1];
		end else if (cmd.round_idx < sha1h_pkg::ROUND_B3) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1h_pkg::ROUND_K[2];
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1h_pkg::ROUND_K[3];
		end
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + wt + k;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], wt};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sha1h_pkg::H_INIT[i];
			end
			bit_cnt_q <= '0;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < 5; i++) begin
					h_q[i] <= sha1h_pkg::H_INIT[i];
				end
				bit_cnt_q <= '0;
			end else begin
				if (cmd.fold) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
				if (cmd.count) begin
					bit_cnt_q <= bit_cnt_q + 64'd8;
				end
			end
		end
	end

	always_comb begin
		case (cmd.word_idx)
			3'd0:    digest_word = h_q[0];
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			3'd4:    digest_word = h_q[4];
			default: digest_word = '0;
		endcase
	end

endmodule

FILE: rtl/core/sha1_byte_stream_hasher_core.sv
// SHA-1 byte stream hasher, top level: joins the controller and the datapath.
// Depends on sha1h_pkg, sha1h_ctrl and sha1h_dp.
//
// Usage: each input transaction carries data_byte with has_byte, and may set
// end_of_message. Bytes are taken one per cycle while in_stall is low.
// A byte that completes a 64-byte block holds in_stall high while the
// single round unit runs 80 rounds and the result is then added into the
// chaining words. An end-of-message transaction starts padding, which
// pushes one pad byte per cycle, apart from the step into the length bytes
// and while a compression runs, and runs one or two further compressions.
// The digest then leaves as five output transactions, H0 first, last_word
// set on H4, one per cycle while out_stall is low. A stalled word holds
// unchanged and no input is taken until the fifth word leaves, after which
// the hasher is back in its initial state. Reset loads the initial chaining
// words and clears the bit count and the fill at once; the block buffer
// needs no clearing.
module sha1_byte_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha1h_pkg::cmd_t cmd;

	sha1h_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.cmd            (cmd)
	);

	sha1h_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.digest_word (digest_word)
	);

endmodule
